[rtl/npc_pkg.sv]
//------------------------------------------------------------------------------
// npc_pkg: shared types and constants for the near plane polygon clipper
// Register indexes, defaults, the front-to-back item record and FSM states.
//------------------------------------------------------------------------------
package npc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_AW        = 5;

  localparam logic [2:0] REG_ZX   = 3'd0;
  localparam logic [2:0] REG_ZY   = 3'd1;
  localparam logic [2:0] REG_ZZ   = 3'd2;
  localparam logic [2:0] REG_ZOFF = 3'd3;
  localparam logic [2:0] REG_NEAR = 3'd4;

  localparam logic signed [31:0] ZZ_RESET   = 32'sd65536;
  localparam logic [30:0]        NEAR_RESET = 31'd1966;

  // one classified vertex handed from front to back
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] d;
    logic               last;
  } vtx_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_E1_A,
    BK_E1_DIV,
    BK_E1_MUL,
    BK_E2_A,
    BK_E2_DIV,
    BK_E2_MUL,
    BK_FIN,
    BK_FLUSH
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_SUM
  } fr_state_t;

endpackage

[rtl/npc_front.sv]
//------------------------------------------------------------------------------
// npc_front: accepts vertices and computes their view depth
// Three products on one multiplier, then the saturated sum.
//------------------------------------------------------------------------------
module npc_front #(
  parameter int FRAC_BITS = npc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic                in_final_vertex,
  input  logic signed [31:0]  zx,
  input  logic signed [31:0]  zy,
  input  logic signed [31:0]  zz,
  input  logic signed [31:0]  zoff,
  output logic                v_valid,
  input  logic                v_full,
  output npc_pkg::vtx_t       v_data
);
  import npc_pkg::*;

  fr_state_t state_r, state_nxt;
  vtx_t      vtx_r;
  logic [1:0] k_r, k_nxt;
  logic signed [63:0] prod_r;
  logic signed [63:0] hi_r, hi_nxt;
  logic [FRAC_BITS+1:0] lo_r, lo_nxt;
  logic signed [31:0] ca, pa;
  logic signed [63:0] prod_c;
  logic signed [63:0] sum_c;

  assign in_stall = (state_r != FR_IDLE);

  always_comb begin
    unique case (k_r)
      2'd0:    begin ca = zx; pa = vtx_r.x; end
      2'd1:    begin ca = zy; pa = vtx_r.y; end
      default: begin ca = zz; pa = vtx_r.z; end
    endcase
    prod_c = ca * pa;
  end

  always_comb begin
    sum_c = hi_r + 64'(signed'({1'b0, lo_r} >>> FRAC_BITS)) + 64'(zoff);
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    v_valid   = 1'b0;
    unique case (state_r)
      FR_IDLE: begin
        if (in_valid) begin
          state_nxt = FR_MUL;
          k_nxt     = 2'd0;
          hi_nxt    = '0;
          lo_nxt    = '0;
        end
      end
      FR_MUL: begin
        // accumulate the previous product while the next one forms
        if (k_r != 2'd0) begin
          hi_nxt = hi_r + (prod_r >>> FRAC_BITS);
          lo_nxt = lo_r + (FRAC_BITS+2)'(prod_r[FRAC_BITS-1:0]);
        end
        if (k_r == 2'd2) state_nxt = FR_SUM;
        else k_nxt = k_r + 2'd1;
      end
      default: begin
        if (!v_full) begin
          v_valid   = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r  <= k_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (state_r == FR_MUL) prod_r <= prod_c;
    if (state_r == FR_IDLE && in_valid) begin
      vtx_r.x    <= in_pos_x;
      vtx_r.y    <= in_pos_y;
      vtx_r.z    <= in_pos_z;
      vtx_r.d    <= '0;
      vtx_r.last <= in_final_vertex;
    end
  end

  // last product folds in at the sum step
  logic signed [63:0] tot_c;
  always_comb begin
    tot_c = sum_c + (prod_r >>> FRAC_BITS)
          + 64'(signed'({1'b0, (FRAC_BITS+2)'(lo_r + (FRAC_BITS+2)'(prod_r[FRAC_BITS-1:0]))}
              >>> FRAC_BITS))
          - 64'(signed'({1'b0, lo_r} >>> FRAC_BITS));
    v_data   = vtx_r;
    if (tot_c > 64'sd2147483647)       v_data.d = 32'sh7fffffff;
    else if (tot_c < -64'sd2147483648) v_data.d = 32'sh80000000;
    else                               v_data.d = tot_c[31:0];
  end

endmodule

[rtl/npc_fifo.sv]
//------------------------------------------------------------------------------
// npc_fifo: short queue of classified vertices between front and back
// Two entries, registered pointers.
//------------------------------------------------------------------------------
module npc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  npc_pkg::vtx_t wr_data,
  output logic          full,
  output logic          not_empty,
  input  logic          rd_en,
  output npc_pkg::vtx_t rd_data
);
  import npc_pkg::*;

  vtx_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

[rtl/npc_div.sv]
//------------------------------------------------------------------------------
// npc_div: restoring divider for the crossing fraction
// Produces floor(num * 2^FRAC_BITS / den), num < den, one quotient bit a cycle.
//------------------------------------------------------------------------------
module npc_div #(
  parameter int FRAC_BITS = npc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [32:0]       num,
  input  logic [32:0]       den,
  output logic              done,
  output logic [FRAC_BITS:0] quo
);
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [33:0]         rem_r;
  logic [32:0]         den_r;
  logic [FRAC_BITS:0]  q_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic [33:0]         sh_c;

  assign sh_c = {rem_r[32:0], 1'b0};
  assign done = busy_r && (cnt_r == '0);
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
      cnt_r <= CW'(FRAC_BITS);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (sh_c >= {1'b0, den_r}) begin
        rem_r <= sh_c - {1'b0, den_r};
        q_r   <= {q_r[FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_r <= sh_c;
        q_r   <= {q_r[FRAC_BITS-1:0], 1'b0};
      end
    end
  end

endmodule

[rtl/npc_back.sv]
//------------------------------------------------------------------------------
// npc_back: edge processing, result holding and output register
// Runs incoming and closing edges through one divider and one multiplier.
//------------------------------------------------------------------------------
module npc_back #(
  parameter int FRAC_BITS = npc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  npc_pkg::vtx_t      q_data,
  output logic               q_pop,
  input  logic [30:0]        near_depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_end_of_polygon,
  output logic               out_polygon_empty
);
  import npc_pkg::*;

  bk_state_t state_r, state_nxt;

  vtx_t cur_r, first_r, prev_r;
  logic [1:0] nin_r, nout_r;
  // pend slots: 0..2 held/new, up to 6 entries
  logic signed [31:0] px_r [6];
  logic signed [31:0] py_r [6];
  logic signed [31:0] pz_r [6];
  logic [2:0] np_r, rd_r, nheld_r;
  logic [1:0] ax_r;

  // edge operands
  vtx_t ea, eb;
  logic ia, ib;
  logic signed [33:0] den_s, num_s;
  logic [32:0] den_a, num_a;
  logic [FRAC_BITS:0] t_r;
  logic div_start, div_done;
  logic [FRAC_BITS:0] div_q;

  logic is_e2;
  assign is_e2 = (state_r == BK_E2_A) || (state_r == BK_E2_DIV) || (state_r == BK_E2_MUL);
  assign ea = is_e2 ? cur_r : prev_r;
  assign eb = is_e2 ? first_r : cur_r;
  assign ia = ($signed({ea.d[31], ea.d}) <= -$signed({2'b0, near_depth}));
  assign ib = ($signed({eb.d[31], eb.d}) <= -$signed({2'b0, near_depth}));

  always_comb begin
    den_s = 34'(eb.d) - 34'(ea.d);
    num_s = -$signed({3'b0, near_depth}) - 34'(ea.d);
    if (den_s < 0) begin
      den_s = -den_s;
      num_s = -num_s;
    end
    den_a = den_s[32:0];
    num_a = num_s[32:0];
  end

  npc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_a), .den(den_a),
    .done(div_done), .quo(div_q)
  );

  // one-axis interpolation multiplier
  logic signed [31:0] a_c, b_c;
  logic signed [32:0] diff_c;
  logic signed [FRAC_BITS+33:0] prod_c;
  logic signed [31:0] pt_c;
  always_comb begin
    unique case (ax_r)
      2'd0:    begin a_c = ea.x; b_c = eb.x; end
      2'd1:    begin a_c = ea.y; b_c = eb.y; end
      default: begin a_c = ea.z; b_c = eb.z; end
    endcase
    diff_c = 33'(b_c) - 33'(a_c);
    prod_c = (FRAC_BITS+34)'(diff_c) * $signed({1'b0, t_r});
    pt_c   = 32'((FRAC_BITS+34)'(a_c) + (prod_c >>> FRAC_BITS));
  end

  // output register
  logic ov_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic oe_r, oy_emp_r;
  logic out_free;
  assign out_valid          = ov_r;
  assign out_x              = ox_r;
  assign out_y              = oy_r;
  assign out_z              = oz_r;
  assign out_end_of_polygon = oe_r;
  assign out_polygon_empty  = oy_emp_r;
  assign out_free           = !ov_r || !out_stall;

  logic [2:0] total_c;
  always_comb begin
    total_c = {1'b0, nout_r} + (np_r - nheld_r);
    if (total_c > 3'd3) total_c = 3'd3;
  end

  logic empty_c, emit_c, push_c;
  logic [2:0] np_nxt;
  logic [2:0] flush_end;
  // fewer than three vertices counting this one, or fewer than three results
  assign empty_c = (nin_r < 2'd2) || (total_c < 3'd3);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    push_c    = 1'b0;
    emit_c    = 1'b0;
    unique case (state_r)
      BK_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_nxt = BK_E1_A;
      end
      BK_E1_A, BK_E2_A: begin
        // skip the opening vertex's first edge
        if (state_r == BK_E1_A && nin_r == 2'd0) begin
          state_nxt = cur_r.last ? BK_E2_A : BK_FIN;
        end else if (ax_r == 2'd0) begin
          // ax_r==0: emit start if inside
          push_c = ia;
          if (ia != ib && den_s != 0) begin
            div_start = 1'b1;
            state_nxt = is_e2 ? BK_E2_DIV : BK_E1_DIV;
          end else begin
            state_nxt = is_e2 ? BK_FIN : (cur_r.last ? BK_E2_A : BK_FIN);
          end
        end
      end
      BK_E1_DIV, BK_E2_DIV: if (div_done) begin
        state_nxt = is_e2 ? BK_E2_MUL : BK_E1_MUL;
      end
      BK_E1_MUL, BK_E2_MUL: if (ax_r == 2'd2) begin
        state_nxt = is_e2 ? BK_FIN : (cur_r.last ? BK_E2_A : BK_FIN);
      end
      BK_FIN: state_nxt = BK_FLUSH;
      default: begin
        if (rd_r == flush_end) state_nxt = BK_IDLE;
        else if (out_free) emit_c = 1'b1;
      end
    endcase
  end

  // flush range is set at FIN
  logic [2:0] fend_r;
  logic       fempty_r, flast_r;
  assign flush_end = fend_r;

  always_comb begin
    np_nxt = np_r + {2'b0, push_c};
    if ((state_r == BK_E1_MUL || state_r == BK_E2_MUL) && ax_r == 2'd2)
      np_nxt = np_r + 3'd1;
    if (state_r == BK_FLUSH && rd_r == flush_end) begin
      if (flast_r) np_nxt = '0;
      else if (total_c >= 3'd3) np_nxt = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
      nin_r   <= '0;
      nout_r  <= '0;
      np_r    <= '0;
      nheld_r <= '0;
      ax_r    <= '0;
      rd_r    <= '0;
      fend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_free) ov_r <= emit_c;
      np_r <= np_nxt;
      if (state_r == BK_IDLE && q_valid) begin
        cur_r <= q_data;
        ax_r  <= '0;
        rd_r  <= '0;
      end
      if ((state_r == BK_E1_DIV || state_r == BK_E2_DIV) && div_done) begin
        // clamp: num<=0 -> 0, num>=den -> one
        if ($signed(num_s) <= 0) t_r <= '0;
        else if (num_s >= den_s) t_r <= (FRAC_BITS+1)'(1) << FRAC_BITS;
        else t_r <= div_q;
        ax_r <= '0;
      end
      if (state_r == BK_E1_MUL || state_r == BK_E2_MUL) begin
        unique case (ax_r)
          2'd0:    px_r[np_r] <= pt_c;
          2'd1:    py_r[np_r] <= pt_c;
          default: pz_r[np_r] <= pt_c;
        endcase
        ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      if (push_c) begin
        px_r[np_r] <= ea.x;
        py_r[np_r] <= ea.y;
        pz_r[np_r] <= ea.z;
      end
      if (state_r == BK_FIN) begin
        if (nin_r == 2'd0) begin
          first_r <= cur_r;
        end
        prev_r <= cur_r;
        rd_r   <= '0;
        flast_r  <= cur_r.last;
        fempty_r <= cur_r.last && empty_c;
        if (cur_r.last) begin
          fend_r <= empty_c ? 3'd1 : np_r;
        end else if (total_c >= 3'd3) begin
          fend_r <= np_r - 3'd1;
        end else begin
          fend_r <= 3'd0;
        end
      end
      if (state_r == BK_FLUSH) begin
        if (emit_c) rd_r <= rd_r + 3'd1;
        if (rd_r == flush_end) begin
          if (flast_r) begin
            nin_r   <= '0;
            nout_r  <= '0;
            nheld_r <= '0;
          end else begin
            if (nin_r != 2'd3) nin_r <= nin_r + 2'd1;
            nout_r <= total_c[1:0];
            if (total_c >= 3'd3) begin
              px_r[0] <= px_r[np_r - 3'd1];
              py_r[0] <= py_r[np_r - 3'd1];
              pz_r[0] <= pz_r[np_r - 3'd1];
              nheld_r <= 3'd1;
            end else begin
              nheld_r <= np_r;
            end
          end
        end
      end
    end
    if (emit_c) begin
      ox_r     <= fempty_r ? 32'sd0 : px_r[rd_r];
      oy_r     <= fempty_r ? 32'sd0 : py_r[rd_r];
      oz_r     <= fempty_r ? 32'sd0 : pz_r[rd_r];
      oe_r     <= flast_r && (rd_r + 3'd1 == flush_end);
      oy_emp_r <= fempty_r;
    end
  end

endmodule

[rtl/near_plane_polygon_clipper_top.sv]
//------------------------------------------------------------------------------
// near_plane_polygon_clipper_top: clips polygons against the near plane
// APB register file, depth front end, vertex queue and edge back end.
//------------------------------------------------------------------------------
// Usage:
//   Vertices enter on in_* (valid/stall), one beat each, in_final_vertex on
//   the last of a polygon. Clipped vertices leave on out_* (valid/stall).
//   Registers: 0 z-from-x, 1 z-from-y, 2 z-from-z, 3 offset, 4 near depth,
//   at byte addresses 4*i; write only while the block is idle.
// Operation:
//   The front computes three products on one multiplier per vertex and
//   stalls its input until that vertex is written to the queue. The back
//   handles each plane crossing with the restoring divider, one bit a cycle,
//   then three multiplies, up to two crossings per vertex, and delivers
//   each result through the output register.
// Reset:
//   rst_n clears the registers to their defaults and starts a new polygon.
// Stall:
//   A valid output beat holds while out_stall is high; the two-entry queue
//   lets the front keep accepting until it fills.
//------------------------------------------------------------------------------
module near_plane_polygon_clipper_top #(
  parameter int FRAC_BITS = npc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [npc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_pos_x,
  input  logic signed [31:0]         in_pos_y,
  input  logic signed [31:0]         in_pos_z,
  input  logic                       in_final_vertex,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_x,
  output logic signed [31:0]         out_y,
  output logic signed [31:0]         out_z,
  output logic                       out_end_of_polygon,
  output logic                       out_polygon_empty
);
  import npc_pkg::*;

  logic signed [31:0] zx_r, zy_r, zz_r, zoff_r;
  logic [30:0]        near_r;
  logic [2:0]         idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zx_r   <= '0;
      zy_r   <= '0;
      zz_r   <= ZZ_RESET;
      zoff_r <= '0;
      near_r <= NEAR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        REG_ZX:   zx_r   <= cfg_pwdata;
        REG_ZY:   zy_r   <= cfg_pwdata;
        REG_ZZ:   zz_r   <= cfg_pwdata;
        REG_ZOFF: zoff_r <= cfg_pwdata;
        REG_NEAR: near_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZX:   cfg_prdata = zx_r;
      REG_ZY:   cfg_prdata = zy_r;
      REG_ZZ:   cfg_prdata = zz_r;
      REG_ZOFF: cfg_prdata = zoff_r;
      REG_NEAR: cfg_prdata = {1'b0, near_r};
      default:  cfg_prdata = '0;
    endcase
  end

  vtx_t f_data, q_data;
  logic f_valid, q_full, q_ne, q_pop;

  npc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_final_vertex(in_final_vertex), .zx(zx_r), .zy(zy_r), .zz(zz_r),
    .zoff(zoff_r), .v_valid(f_valid), .v_full(q_full), .v_data(f_data)
  );

  npc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_data), .full(q_full),
    .not_empty(q_ne), .rd_en(q_pop), .rd_data(q_data)
  );

  npc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_data), .q_pop(q_pop),
    .near_depth(near_r), .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_end_of_polygon(out_end_of_polygon), .out_polygon_empty(out_polygon_empty)
  );

endmodule
